// ----- rtl/core/ipv4_dotted_text_validator_top_assert.svh -----
// ----------------------------------------------------------------------------
// IPv4 dotted text validator assertion macros
// Assertion helpers used by the validator top module.
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_TEXT_VALIDATOR_TOP_ASSERT_SVH
`define IPV4_DOTTED_TEXT_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IPV4V_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4v assertion failed");

// Next-cycle implication, checked out of reset.
`define IPV4V_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4v assertion failed");

`endif

// ----- rtl/core/ipv4v_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 dotted text validator package
// Character codes, limits and the per-text scan state.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE = 8'h39;  // '9'
    localparam logic [7:0] CH_TWO  = 8'h32;  // '2'
    localparam logic [7:0] CH_FIVE = 8'h35;  // '5'
    localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'

    localparam logic [4:0] LEN_MIN = 5'd7;
    localparam logic [4:0] LEN_MAX = 5'd15;
    localparam logic [4:0] LEN_SAT = 5'd16;
    localparam logic [2:0] DOT_REQ = 3'd3;
    localparam logic [2:0] DOT_SAT = 3'd4;
    localparam logic [2:0] DIG_MAX = 3'd3;
    localparam logic [2:0] DIG_SAT = 3'd7;
    localparam logic [8:0] SEG_MAX = 9'd255;
    localparam logic [8:0] SEG_SAT = 9'd256;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_2    = 2'd1,
        PFX_25   = 2'd2,
        PFX_255  = 2'd3
    } t_prefix;

    typedef struct packed {
        logic [4:0] length_count;
        logic [2:0] dot_count;
        logic [2:0] segment_digits;
        logic [8:0] segment_value;
        t_prefix    prefix_match;
        logic       failed;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        length_count:   5'd0,
        dot_count:      3'd0,
        segment_digits: 3'd0,
        segment_value:  9'd0,
        prefix_match:   PFX_NONE,
        failed:         1'b0
    };

endpackage

// ----- rtl/core/ipv4v_step.sv -----
// ----------------------------------------------------------------------------
// IPv4 dotted text validator step logic
// Next scan state and verdict for one character, purely combinational.
// ----------------------------------------------------------------------------
module ipv4v_step (
    input  ipv4v_pkg::t_state i_state,
    input  logic [7:0]        i_symbol,
    output ipv4v_pkg::t_state o_state,
    output logic              o_ok
);

    logic        is_digit;
    logic        is_dot;
    logic        pos0;
    logic        pos1;
    logic        pos2;
    logic [3:0]  digit;
    logic [11:0] seg_acc;
    logic [2:0]  dots_inc;

    assign is_digit = (i_symbol >= ipv4v_pkg::CH_ZERO) && (i_symbol <= ipv4v_pkg::CH_NINE);
    assign is_dot   = (i_symbol == ipv4v_pkg::CH_DOT);
    assign pos0     = (i_state.length_count == 5'd0);
    assign pos1     = (i_state.length_count == 5'd1);
    assign pos2     = (i_state.length_count == 5'd2);
    assign digit    = 4'(i_symbol - ipv4v_pkg::CH_ZERO);
    // value * 10 + digit; value is at most 256 so 12 bits suffice
    assign seg_acc  = {i_state.segment_value, 3'b000} + {2'b00, i_state.segment_value, 1'b0}
                    + {8'd0, digit};
    assign dots_inc = (i_state.dot_count < ipv4v_pkg::DOT_SAT) ?
                      i_state.dot_count + 3'd1 : i_state.dot_count;

    always_comb begin
        o_state = i_state;

        if (pos0 && ((i_symbol == ipv4v_pkg::CH_ZERO) || is_dot)) begin
            o_state.failed = 1'b1;
        end

        // leading "255" rejects the text
        if (pos0) begin
            o_state.prefix_match = (i_symbol == ipv4v_pkg::CH_TWO) ?
                                   ipv4v_pkg::PFX_2 : ipv4v_pkg::PFX_NONE;
        end else if (pos1) begin
            o_state.prefix_match = ((i_state.prefix_match == ipv4v_pkg::PFX_2) &&
                                    (i_symbol == ipv4v_pkg::CH_FIVE)) ?
                                   ipv4v_pkg::PFX_25 : ipv4v_pkg::PFX_NONE;
        end else if (pos2) begin
            if ((i_state.prefix_match == ipv4v_pkg::PFX_25) &&
                (i_symbol == ipv4v_pkg::CH_FIVE)) begin
                o_state.prefix_match = ipv4v_pkg::PFX_255;
                o_state.failed       = 1'b1;
            end else begin
                o_state.prefix_match = ipv4v_pkg::PFX_NONE;
            end
        end

        if (is_digit) begin
            o_state.segment_value = (seg_acc > 12'(ipv4v_pkg::SEG_SAT)) ?
                                    ipv4v_pkg::SEG_SAT : seg_acc[8:0];
            if (i_state.segment_digits < ipv4v_pkg::DIG_SAT) begin
                o_state.segment_digits = i_state.segment_digits + 3'd1;
            end
        end else if (is_dot) begin
            o_state.dot_count = dots_inc;
            if ((dots_inc > ipv4v_pkg::DOT_REQ) ||
                (i_state.segment_digits > ipv4v_pkg::DIG_MAX) ||
                (i_state.segment_value > ipv4v_pkg::SEG_MAX)) begin
                o_state.failed = 1'b1;
            end
            o_state.segment_value  = 9'd0;
            o_state.segment_digits = 3'd0;
        end else begin
            o_state.failed = 1'b1;
        end

        if (i_state.length_count < ipv4v_pkg::LEN_SAT) begin
            o_state.length_count = i_state.length_count + 5'd1;
        end
    end

    assign o_ok = !o_state.failed
               && (o_state.length_count >= ipv4v_pkg::LEN_MIN)
               && (o_state.length_count <= ipv4v_pkg::LEN_MAX)
               && !is_dot
               && (o_state.dot_count == ipv4v_pkg::DOT_REQ)
               && (o_state.segment_value <= ipv4v_pkg::SEG_MAX);

endmodule

// ----- rtl/core/ipv4_dotted_text_validator_top.sv -----
// ----------------------------------------------------------------------------
// IPv4 dotted text validator
// Checks a character stream for a well-formed dotted IPv4 address.
// ----------------------------------------------------------------------------
// Input channel: one character per transaction (i_symbol), with i_final_req
// set on the last character of a text. Output channel: one transaction per
// text carrying o_valid_res, 1 when the text is an accepted address.
// Every character is scanned in the cycle it is accepted; the scan state is
// one small register set updated by the step logic, so one character per
// clock is sustained unless a final character is held off. The verdict is
// registered on the output in the cycle after the final character is accepted.
// Characters that are not final are taken even while a verdict waits on a
// stalled output; a final character is held off until the output register
// is free or is being drained in the same cycle.
// Scan state clears after every final character. Reset (i_rst_n low,
// synchronous) clears the scan state and drops o_res_valid.
// ----------------------------------------------------------------------------
`include "ipv4_dotted_text_validator_top_assert.svh"

module ipv4_dotted_text_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_final_req,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_valid_res
);

    ipv4v_pkg::t_state r_state;
    ipv4v_pkg::t_state n_state;
    ipv4v_pkg::t_state step_state;
    logic              step_ok;
    logic              r_res_valid;
    logic              n_res_valid;
    logic              r_valid_res;
    logic              n_valid_res;
    logic              in_acc;

    ipv4v_step u_step (
        .i_state  (r_state),
        .i_symbol (i_symbol),
        .o_state  (step_state),
        .o_ok     (step_ok)
    );

    assign o_in_ready = !r_res_valid || i_res_ready || !i_final_req;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_res_valid = r_res_valid;
        n_valid_res = r_valid_res;
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end
        if (in_acc) begin
            if (i_final_req) begin
                n_state     = ipv4v_pkg::STATE_CLEAR;
                n_res_valid = 1'b1;
                n_valid_res = step_ok;
            end else begin
                n_state = step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipv4v_pkg::STATE_CLEAR;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid_res <= n_valid_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_valid_res = r_valid_res;

    // a final character always yields a verdict next cycle
    `IPV4V_ASSERT_NXT(a_final_gives_res, i_clk, i_rst_n, in_acc && i_final_req, r_res_valid)
    // scan state is clean after a final character
    `IPV4V_ASSERT_NXT(a_final_clears, i_clk, i_rst_n, in_acc && i_final_req,
                      r_state.length_count == 5'd0 && !r_state.failed)
    // a waiting verdict is never overwritten
    `IPV4V_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_res_valid && !i_res_ready,
                      !(in_acc && i_final_req))
    // counters stay within their saturation limits
    `IPV4V_ASSERT_IMP(a_sat_limits, i_clk, i_rst_n, 1'b1,
                      r_state.length_count <= ipv4v_pkg::LEN_SAT &&
                      r_state.dot_count <= ipv4v_pkg::DOT_SAT &&
                      r_state.segment_value <= ipv4v_pkg::SEG_SAT)

endmodule
